// ===== sv/tml_pkg.sv =====
// Package for the texture miptree layout block: types, constants, helpers.
// Used by tml_front, tml_queue, tml_back and texture_miptree_layout.
`default_nettype none
package tml_pkg;

  localparam int MAX_LEVELS       = 15;
  localparam int CACHE_LINE_BYTES = 128;
  localparam int PAGE_BYTES       = 16384;
  localparam int POS_W            = 44;

  typedef struct packed {
    logic [31:0] offset;
    logic [20:0] stride;
    logic [14:0] tile_w;
    logic [14:0] tile_h;
  } tml_entry_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  nlev;
    logic [31:0] layer;
    logic [43:0] total;
    logic        paged;
  } tml_summary_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DIVW, F_DIVH, F_SETUP, F_SPLIT, F_POT, F_LDIV, F_LA, F_LB,
    F_LIN, F_LIN2, F_FIN1, F_FIN2, F_FIN3
  } tml_fstate_t;

  // index of highest set bit plus one
  function automatic logic [4:0] bit_len(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [4:0] ceil_log2(input logic [15:0] v);
    return (v <= 16'd1) ? 5'd0 : bit_len(v - 16'd1);
  endfunction

endpackage
`default_nettype wire

// ===== sv/tml_div.sv =====
// Shared iterative divider, one quotient bit per cycle.
// Standalone; used by tml_front.
`default_nettype none
module tml_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] num,
  input  wire logic [3:0]  den,
  output logic             done,
  output logic [15:0]      quo
);
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt, rem_r, rem_nxt, den_r, den_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [4:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[15]};
    if (!busy_r) begin
      if (start && !done_r) begin
        busy_nxt = 1'b1;
        cnt_nxt  = 4'd0;
        rem_nxt  = 4'd0;
        quo_nxt  = num;
        den_nxt  = den;
      end
    end else begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 4'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[3:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== sv/tml_front.sv =====
// Front part: takes a texture description, walks the levels and pushes one
// level record per level into the queue, then hands over the summary.
// Depends on tml_pkg and tml_div.
`default_nettype none
module tml_front import tml_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire logic        tiling_mode,
  input  wire logic [14:0] tex_width,
  input  wire logic [14:0] tex_height,
  input  wire logic [11:0] tex_depth,
  input  wire logic [6:0]  bytes_per_block,
  input  wire logic [3:0]  block_width,
  input  wire logic [3:0]  block_height,
  input  wire logic [5:0]  usage_flags,
  input  wire logic [20:0] forced_stride,
  output logic             busy,
  output logic             push,
  output tml_entry_t       push_entry,
  output tml_summary_t     summary
);
  tml_fstate_t state_r, state_nxt;

  logic        tiled_r, tiled_nxt;
  logic [14:0] w_r, w_nxt, h_r, h_nxt, wel_r, wel_nxt, hel_r, hel_nxt, mn_r, mn_nxt;
  logic [11:0] d_r, d_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [6:0]  bpb_r, bpb_nxt;
  logic [3:0]  bw_r, bw_nxt, bh_r, bh_nxt, nlev_r, nlev_nxt, lvl_r, lvl_nxt;
  logic [5:0]  fl_r, fl_nxt;
  logic [20:0] fs_r, fs_nxt;
  logic [2:0]  ltw_r, ltw_nxt, lth_r, lth_nxt;
  logic [22:0] area_r, area_nxt;
  logic [18:0] pw_r, pw_nxt, ph_r, ph_nxt;
  logic [10:0] limw_r, limw_nxt, limh_r, limh_nxt;
  logic [4:0]  split_r, split_nxt, lqw_r, lqw_nxt, lqh_r, lqh_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, bytes_r, bytes_nxt, layer_r, layer_nxt;
  logic [15:0] q_r, q_nxt;
  logic [21:0] slin_r, slin_nxt;
  logic        tl_r, tl_nxt, paged_r, paged_nxt;
  logic [55:0] prod_r, prod_nxt;
  tml_entry_t  ent_r, ent_nxt, lin_entry;

  logic        div_start, div_done;
  logic [15:0] div_num, div_quo;
  logic [3:0]  div_den;

  // scratch
  logic [14:0] wn, hn, xs;
  logic [15:0] major, s16;
  logic [4:0]  nl, kk, c5, lt;
  logic [7:0]  twm1, thm1;
  logic [11:0] msk;
  logic        pl, pb, stop, tl;
  logic [23:0] tiles;
  logic [30:0] bt;
  logic [22:0] lin_t;
  logic [56:0] tot57;
  logic [43:0] tot44;

  tml_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    xs = w_r >> lvl_r;
    if (xs == 15'd0) xs = 15'd1;
    div_start = (state_r == F_DIVW) || (state_r == F_DIVH) || (state_r == F_LDIV);
    case (state_r)
      F_DIVH: begin
        div_num = 16'(h_r) + 16'(bh_r) - 16'd1;
        div_den = bh_r;
      end
      F_LDIV: begin
        div_num = 16'(xs) + 16'(bw_r) - 16'd1;
        div_den = bw_r;
      end
      default: begin
        div_num = 16'(w_r) + 16'(bw_r) - 16'd1;
        div_den = bw_r;
      end
    endcase
  end

  assign stop = (pw_r <= 19'(limw_r)) || (ph_r <= 19'(limh_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (load) state_nxt = F_DIVW;
      F_DIVW:  if (div_done) state_nxt = tiled_r ? F_DIVH : F_LIN;
      F_DIVH:  if (div_done) state_nxt = F_SETUP;
      F_SETUP: state_nxt = F_SPLIT;
      F_SPLIT: if (stop) state_nxt = F_POT;
      F_POT:   state_nxt = F_LDIV;
      F_LDIV:  if (div_done) state_nxt = F_LA;
      F_LA:    state_nxt = F_LB;
      F_LB:    state_nxt = (5'(lvl_r) + 5'd1 == 5'(nlev_r)) ? F_FIN1 : F_LDIV;
      F_LIN:   state_nxt = F_LIN2;
      F_LIN2:  state_nxt = F_FIN2;
      F_FIN1:  state_nxt = F_FIN2;
      F_FIN2:  state_nxt = F_FIN3;
      F_FIN3:  state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    tiled_nxt = tiled_r; w_nxt = w_r; h_nxt = h_r; d_nxt = d_r; bpb_nxt = bpb_r;
    bw_nxt = bw_r; bh_nxt = bh_r; fl_nxt = fl_r; fs_nxt = fs_r; nlev_nxt = nlev_r;
    wel_nxt = wel_r; hel_nxt = hel_r; mn_nxt = mn_r; sx_nxt = sx_r; sy_nxt = sy_r;
    ltw_nxt = ltw_r; lth_nxt = lth_r; area_nxt = area_r; pw_nxt = pw_r; ph_nxt = ph_r;
    limw_nxt = limw_r; limh_nxt = limh_r; split_nxt = split_r; lqw_nxt = lqw_r;
    lqh_nxt = lqh_r; pos_nxt = pos_r; bytes_nxt = bytes_r; layer_nxt = layer_r;
    q_nxt = q_r; slin_nxt = slin_r; tl_nxt = tl_r; paged_nxt = paged_r;
    prod_nxt = prod_r; ent_nxt = ent_r; lvl_nxt = lvl_r;
    wn = (tex_width == 15'd0) ? 15'd1 : tex_width;
    hn = (tex_height == 15'd0) ? 15'd1 : tex_height;
    major = 16'((wn > hn) ? wn : hn);
    nl = 5'd1; kk = 5'd0; c5 = 5'd0; lt = 5'd0; s16 = 16'd0;
    twm1 = 8'd0; thm1 = 8'd0; msk = 12'd0; pl = 1'b0; pb = 1'b0; tl = 1'b0;
    tiles = 24'd0; bt = 31'd0; lin_t = 23'd0;
    case (state_r)
      F_IDLE: if (load) begin
        tiled_nxt = tiling_mode;
        w_nxt = wn; h_nxt = hn;
        d_nxt = (tex_depth == 12'd0) ? 12'd1 : tex_depth;
        bpb_nxt = (bytes_per_block == 7'd0) ? 7'd1 : bytes_per_block;
        bw_nxt = (block_width == 4'd0) ? 4'd1 : block_width;
        bh_nxt = (block_height == 4'd0) ? 4'd1 : block_height;
        fl_nxt = usage_flags; fs_nxt = forced_stride;
        if (usage_flags[5] && 16'(tex_depth) > major) major = 16'(tex_depth);
        if (tiling_mode && usage_flags[4]) nl = bit_len(major);
        if (nl > 5'(MAX_LEVELS)) nl = 5'(MAX_LEVELS);
        if (nl == 5'd0) nl = 5'd1;
        nlev_nxt = 4'(nl);
      end
      F_DIVW: if (div_done) wel_nxt = div_quo[14:0];
      F_DIVH: if (div_done) hel_nxt = div_quo[14:0];
      F_SETUP: begin
        kk = bit_len(16'(bpb_r)) - 5'd1;
        if (kk > 5'd6) kk = 5'd6;
        ltw_nxt = 3'(5'd7 - (kk >> 1));
        lth_nxt = 3'(5'd7 - ((kk + 5'd1) >> 1));
        twm1 = (8'd1 << ltw_nxt) - 8'd1;
        thm1 = (8'd1 << lth_nxt) - 8'd1;
        sx_nxt = 12'((17'(wel_r) + 17'(twm1)) >> ltw_nxt);
        sy_nxt = 12'((17'(hel_r) + 17'(thm1)) >> lth_nxt);
        pw_nxt = 19'(bw_r) * 19'(wel_r);
        ph_nxt = 19'(bh_r) * 19'(hel_r);
        limw_nxt = 11'(bw_r) * 11'(twm1);
        limh_nxt = 11'(bh_r) * 11'(thm1);
        split_nxt = 5'd0;
      end
      F_SPLIT: begin
        area_nxt = 23'(sx_r) * 23'(sy_r);
        if (!stop) begin
          pw_nxt = (pw_r >> 1 == 19'd0) ? 19'd1 : pw_r >> 1;
          ph_nxt = (ph_r >> 1 == 19'd0) ? 19'd1 : ph_r >> 1;
          split_nxt = split_r + 5'd1;
        end
      end
      F_POT: begin
        if (fl_r[0]) begin
          c5 = ceil_log2(16'(wel_r));
          lqw_nxt = (c5 > split_r) ? c5 - split_r : 5'd0;
          c5 = ceil_log2(16'(hel_r));
          lqh_nxt = (c5 > split_r) ? c5 - split_r : 5'd0;
        end else begin
          s16 = 16'(wel_r) >> split_r;
          if (s16 == 16'd0) s16 = 16'd1;
          lqw_nxt = ceil_log2(s16);
          s16 = 16'(hel_r) >> split_r;
          if (s16 == 16'd0) s16 = 16'd1;
          lqh_nxt = ceil_log2(s16);
        end
        mn_nxt = (wel_r < hel_r) ? wel_r : hel_r;
        pos_nxt = '0;
        lvl_nxt = 4'd0;
      end
      F_LDIV: if (div_done) q_nxt = div_quo;
      F_LA: begin
        tl = 5'(lvl_r) < split_r;
        msk = (12'd1 << lvl_r) - 12'd1;
        pl = |(sx_r & msk);
        pb = |(sy_r & msk);
        tiles = 24'(area_r >> (5'(lvl_r) << 1));
        if (pl) tiles = tiles + 24'(sy_r >> lvl_r);
        if (pb) tiles = tiles + 24'(sx_r >> lvl_r);
        if (pl && pb) tiles = tiles + 24'd1;
        bt = 31'(bpb_r) * 31'(tiles);
        ent_nxt.offset = (pos_r > POS_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : pos_r[31:0];
        if (tl) begin
          bytes_nxt = POS_W'(bt) << (4'(ltw_r) + 4'(lth_r));
          ent_nxt.stride = 21'(q_r) + 21'(fl_r[0] && pl);
          ent_nxt.tile_w = 15'(16'd1 << ltw_r);
          ent_nxt.tile_h = 15'(16'd1 << lth_r);
        end else begin
          bytes_nxt = POS_W'(bpb_r) << (6'(lqw_r) + 6'(lqh_r));
          ent_nxt.stride = 21'(q_r);
          if (fl_r[0]) begin
            lt = (lqw_r < lqh_r) ? lqw_r : lqh_r;
          end else begin
            s16 = 16'(mn_r >> lvl_r);
            if (s16 == 16'd0) s16 = 16'd1;
            lt = ceil_log2(s16);
          end
          ent_nxt.tile_w = (lt >= 5'd15) ? 15'h7FFF : 15'(16'd1 << lt);
          ent_nxt.tile_h = ent_nxt.tile_w;
        end
        tl_nxt = tl;
      end
      F_LB: begin
        pos_nxt = (pos_r + bytes_r + POS_W'(CACHE_LINE_BYTES - 1))
                  & ~POS_W'(CACHE_LINE_BYTES - 1);
        if (!tl_r) begin
          lqw_nxt = (lqw_r == 5'd0) ? 5'd0 : lqw_r - 5'd1;
          lqh_nxt = (lqh_r == 5'd0) ? 5'd0 : lqh_r - 5'd1;
        end
        lvl_nxt = lvl_r + 4'd1;
      end
      F_LIN: begin
        lin_t = (23'(wel_r) * 23'(bpb_r) + 23'(CACHE_LINE_BYTES - 1))
                & ~23'(CACHE_LINE_BYTES - 1);
        slin_nxt = (fs_r != 21'd0) ? 22'(fs_r) : lin_t[21:0];
      end
      F_LIN2: begin
        layer_nxt = (POS_W'(37'(slin_r) * 37'(h_r)) + POS_W'(CACHE_LINE_BYTES - 1))
                    & ~POS_W'(CACHE_LINE_BYTES - 1);
        paged_nxt = 1'b0;
      end
      F_FIN1: begin
        tl = (nlev_r != 4'd1) && (pos_r > POS_W'(PAGE_BYTES));
        if (d_r == 12'd1 && !fl_r[1]) tl = 1'b0;
        if (fl_r[2]) tl = 1'b1;
        if (fl_r[3] && d_r > 12'd1) tl = 1'b1;
        paged_nxt = tl;
        layer_nxt = tl ? ((pos_r + POS_W'(PAGE_BYTES - 1)) & ~POS_W'(PAGE_BYTES - 1))
                       : pos_r;
      end
      F_FIN2: prod_nxt = 56'(layer_r) * 56'(d_r);
      default: ;
    endcase
  end

  always_comb begin
    lin_entry.offset = 32'd0;
    lin_entry.stride = (slin_r > 22'h1F_FFFF) ? 21'h1F_FFFF : slin_r[20:0];
    lin_entry.tile_w = 15'd0;
    lin_entry.tile_h = 15'd0;
    push       = (state_r == F_LB) || (state_r == F_LIN2);
    push_entry = (state_r == F_LIN2) ? lin_entry : ent_r;
    tot57 = (57'(prod_r) + 57'(CACHE_LINE_BYTES - 1)) & ~57'(CACHE_LINE_BYTES - 1);
    tot44 = (tot57 > 57'(44'hFFF_FFFF_FFFF)) ? 44'hFFF_FFFF_FFFF : tot57[43:0];
    summary.valid = (state_r == F_FIN3);
    summary.nlev  = nlev_r;
    summary.layer = (layer_r > POS_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : layer_r[31:0];
    summary.total = tot44;
    summary.paged = paged_r;
    busy = (state_r != F_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
    tiled_r <= tiled_nxt; w_r <= w_nxt; h_r <= h_nxt; d_r <= d_nxt; bpb_r <= bpb_nxt;
    bw_r <= bw_nxt; bh_r <= bh_nxt; fl_r <= fl_nxt; fs_r <= fs_nxt; nlev_r <= nlev_nxt;
    wel_r <= wel_nxt; hel_r <= hel_nxt; mn_r <= mn_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    ltw_r <= ltw_nxt; lth_r <= lth_nxt; area_r <= area_nxt; pw_r <= pw_nxt;
    ph_r <= ph_nxt; limw_r <= limw_nxt; limh_r <= limh_nxt; split_r <= split_nxt;
    lqw_r <= lqw_nxt; lqh_r <= lqh_nxt; pos_r <= pos_nxt; bytes_r <= bytes_nxt;
    layer_r <= layer_nxt; q_r <= q_nxt; slin_r <= slin_nxt; tl_r <= tl_nxt;
    paged_r <= paged_nxt; prod_r <= prod_nxt; ent_r <= ent_nxt; lvl_r <= lvl_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/tml_queue.sv =====
// Level record queue between front and back, sixteen entries.
// Depends on tml_pkg.
`default_nettype none
module tml_queue import tml_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire tml_entry_t wr_data,
  input  wire logic       pop,
  output tml_entry_t      rd_data,
  output logic            empty
);
  tml_entry_t mem_r [16];
  logic [3:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 4'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 4'd1 : rp_r;
    cnt_nxt = cnt_r + 5'(push) - 5'(pop);
    empty   = (cnt_r == 5'd0);
    rd_data = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 4'd0;
      rp_r  <= 4'd0;
      cnt_r <= 5'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// ===== sv/tml_back.sv =====
// Back part: once the summary arrives, drains the queue one level per cycle
// into the registered result ports. Depends on tml_pkg.
`default_nettype none
module tml_back import tml_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire tml_summary_t summary,
  input  wire tml_entry_t   q_data,
  input  wire logic         q_empty,
  output logic        pop,
  output logic        active,
  output logic        out_valid,
  output logic [3:0]  out_level_index,
  output logic [31:0] out_level_offset,
  output logic [20:0] out_row_stride,
  output logic [14:0] out_tile_width,
  output logic [14:0] out_tile_height,
  output logic [31:0] out_layer_stride,
  output logic [43:0] out_total_size,
  output logic        out_page_aligned,
  output logic        out_last_level
);
  logic         act_r, act_nxt, vld_r, vld_nxt, last;
  logic [3:0]   idx_r, idx_nxt;
  tml_summary_t sum_r, sum_nxt;
  tml_entry_t   o_r, o_nxt;
  logic [3:0]   oidx_r, oidx_nxt;
  logic         olast_r, olast_nxt;

  always_comb begin
    act_nxt = act_r; idx_nxt = idx_r; sum_nxt = sum_r;
    o_nxt = o_r; oidx_nxt = oidx_r; olast_nxt = olast_r;
    vld_nxt = 1'b0;
    last = (5'(idx_r) + 5'd1 == 5'(sum_r.nlev));
    pop = act_r && !q_empty;
    if (summary.valid) begin
      act_nxt = 1'b1;
      idx_nxt = 4'd0;
      sum_nxt = summary;
    end else if (pop) begin
      vld_nxt   = 1'b1;
      o_nxt     = q_data;
      oidx_nxt  = idx_r;
      olast_nxt = last;
      idx_nxt   = idx_r + 4'd1;
      if (last) act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      vld_r <= vld_nxt;
    end
    idx_r <= idx_nxt; sum_r <= sum_nxt; o_r <= o_nxt;
    oidx_r <= oidx_nxt; olast_r <= olast_nxt;
  end

  assign active           = act_r;
  assign out_valid        = vld_r;
  assign out_level_index  = oidx_r;
  assign out_level_offset = o_r.offset;
  assign out_row_stride   = o_r.stride;
  assign out_tile_width   = o_r.tile_w;
  assign out_tile_height  = o_r.tile_h;
  assign out_layer_stride = olast_r ? sum_r.layer : 32'd0;
  assign out_total_size   = olast_r ? sum_r.total : 44'd0;
  assign out_page_aligned = sum_r.paged;
  assign out_last_level   = olast_r;
endmodule
`default_nettype wire

// ===== sv/texture_miptree_layout.sv =====
// Top level of the texture miptree layout block.
// Depends on tml_pkg, tml_front, tml_queue, tml_back.
//
//   channel   handshake                 payload
//   input     start & !busy accepts     in_* (nine fields)
//   result    out_valid, one cycle      out_* (nine fields)
//
// The shared divider computes the width in blocks for every transaction and,
// when twiddled, also the height and the row stride of every level. Linear:
// a single result per transaction. Twiddled: one result per level; after the
// first, the rest follow one per cycle.
// Reset is synchronous and clears control only. busy drops in the cycle that
// carries the last result of a transaction; results cannot be stalled.
`default_nettype none
module texture_miptree_layout import tml_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_tiling_mode,
  input  wire logic [14:0] in_width,
  input  wire logic [14:0] in_height,
  input  wire logic [11:0] in_depth,
  input  wire logic [6:0]  in_bytes_per_block,
  input  wire logic [3:0]  in_block_width,
  input  wire logic [3:0]  in_block_height,
  input  wire logic [5:0]  in_usage_flags,
  input  wire logic [20:0] in_forced_stride,
  output logic             out_valid,
  output logic [3:0]       out_level_index,
  output logic [31:0]      out_level_offset,
  output logic [20:0]      out_row_stride,
  output logic [14:0]      out_tile_width,
  output logic [14:0]      out_tile_height,
  output logic [31:0]      out_layer_stride,
  output logic [43:0]      out_total_size,
  output logic             out_page_aligned,
  output logic             out_last_level
);
  logic         front_busy, back_active, push, pop, q_empty;
  tml_entry_t   push_entry, q_data;
  tml_summary_t summary;

  assign busy = front_busy | back_active;

  tml_front u_front (
    .clk(clk), .rst_n(rst_n), .load(start && !busy),
    .tiling_mode(in_tiling_mode), .tex_width(in_width), .tex_height(in_height),
    .tex_depth(in_depth), .bytes_per_block(in_bytes_per_block),
    .block_width(in_block_width), .block_height(in_block_height),
    .usage_flags(in_usage_flags), .forced_stride(in_forced_stride),
    .busy(front_busy), .push(push), .push_entry(push_entry), .summary(summary)
  );

  tml_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_data(push_entry),
    .pop(pop), .rd_data(q_data), .empty(q_empty)
  );

  tml_back u_back (
    .clk(clk), .rst_n(rst_n), .summary(summary), .q_data(q_data), .q_empty(q_empty),
    .pop(pop), .active(back_active), .out_valid(out_valid),
    .out_level_index(out_level_index), .out_level_offset(out_level_offset),
    .out_row_stride(out_row_stride), .out_tile_width(out_tile_width),
    .out_tile_height(out_tile_height), .out_layer_stride(out_layer_stride),
    .out_total_size(out_total_size), .out_page_aligned(out_page_aligned),
    .out_last_level(out_last_level)
  );
endmodule
`default_nettype wire

// ===== bench/tml_checker.sv =====
// Checker for texture_miptree_layout: watches both channels, predicts the
// per-level results of each accepted transaction and compares them in order.
`timescale 1ns / 100ps
module tml_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_tiling_mode,
  input  logic [14:0] in_width,
  input  logic [14:0] in_height,
  input  logic [11:0] in_depth,
  input  logic [6:0]  in_bytes_per_block,
  input  logic [3:0]  in_block_width,
  input  logic [3:0]  in_block_height,
  input  logic [5:0]  in_usage_flags,
  input  logic [20:0] in_forced_stride,
  input  logic        out_valid,
  input  logic [3:0]  out_level_index,
  input  logic [31:0] out_level_offset,
  input  logic [20:0] out_row_stride,
  input  logic [14:0] out_tile_width,
  input  logic [14:0] out_tile_height,
  input  logic [31:0] out_layer_stride,
  input  logic [43:0] out_total_size,
  input  logic        out_page_aligned,
  input  logic        out_last_level,
  output int          fail_count,
  output int          levels_pending
);
  import tml_pkg::*;
  typedef longint unsigned u64;

  typedef struct {
    logic [3:0]  level;
    logic [31:0] offset;
    logic [20:0] stride;
    logic [14:0] tw;
    logic [14:0] th;
    logic [31:0] layer;
    logic [43:0] total;
    logic        paged;
    logic        last;
  } level_desc_t;

  level_desc_t level_q[$];
  int unsigned tile_w_tab[7] = '{128, 128, 64, 64, 32, 32, 16};
  int unsigned tile_h_tab[7] = '{128, 64, 64, 32, 32, 16, 16};

  function automatic u64 div_up(u64 a, u64 b);
    return (a + b - 1) / b;
  endfunction

  function automatic u64 align_up(u64 v, u64 a);
    return div_up(v, a) * a;
  endfunction

  function automatic u64 shrink(u64 v, int unsigned n);
    u64 r;
    r = (n >= 63) ? 0 : (v >> n);
    return (r != 0) ? r : 1;
  endfunction

  function automatic u64 pow2_ceil(u64 v);
    u64 p;
    p = 1;
    while (p < v && p < (64'd1 << 62)) p = p << 1;
    return p;
  endfunction

  function automatic u64 clip(u64 v, u64 m);
    return (v > m) ? m : v;
  endfunction

  task automatic predict_levels();
    u64 off[16], strd[16], tw[16], th[16];
    u64 w, h, d, bpb, bw, bh, fl, layer, total, pos, maj;
    u64 wel, hel, tiw, tih, sx, sy, area, pw, ph, qw, qh, tiles, t;
    bit twid, comp, paged, pl, pb;
    int unsigned nlev, k, split;
    level_desc_t e;
    w = in_width; h = in_height; d = in_depth;
    bpb = in_bytes_per_block; bw = in_block_width; bh = in_block_height;
    fl = in_usage_flags;
    twid = in_tiling_mode; comp = fl[0]; paged = 0; pos = 0; nlev = 1;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (d == 0) d = 1;
    if (bpb == 0) bpb = 1;
    if (bw == 0) bw = 1;
    if (bh == 0) bh = 1;
    if (twid && fl[4]) begin
      maj = (w > h) ? w : h;
      if (fl[5] && d > maj) maj = d;
      nlev = 0;
      while (maj != 0) begin
        nlev++;
        maj = maj >> 1;
      end
    end
    if (nlev > MAX_LEVELS) nlev = MAX_LEVELS;
    if (nlev < 1) nlev = 1;
    if (!twid) begin
      strd[0] = (in_forced_stride != 0) ? u64'(in_forced_stride)
                : align_up(div_up(w, bw) * bpb, CACHE_LINE_BYTES);
      off[0] = 0; tw[0] = 0; th[0] = 0;
      layer = align_up(strd[0] * h, CACHE_LINE_BYTES);
      total = layer * d;
    end else begin
      k = 0; split = 0;
      wel = div_up(w, bw); hel = div_up(h, bh);
      while (k < 6 && (u64'(2) << k) <= bpb) k++;
      tiw = tile_w_tab[k]; tih = tile_h_tab[k];
      sx = div_up(wel, tiw); sy = div_up(hel, tih); area = sx * sy;
      pw = bw * wel; ph = bh * hel;
      while (split < 40) begin
        if (div_up(pw, bw) < tiw || div_up(ph, bh) < tih) break;
        pw = shrink(pw, 1); ph = shrink(ph, 1); split++;
      end
      for (int unsigned l = 0; l < nlev && l < split; l++) begin
        tiles = area >> (2 * l);
        pl = (sx & ((u64'(1) << l) - 1)) != 0;
        pb = (sy & ((u64'(1) << l) - 1)) != 0;
        if (pl) tiles += sy >> l;
        if (pb) tiles += sx >> l;
        if (pl && pb) tiles += 1;
        off[l] = pos;
        pos = align_up(pos + bpb * tiles * tiw * tih, CACHE_LINE_BYTES);
        strd[l] = div_up(shrink(w, l), bw) + ((comp && pl) ? 1 : 0);
        tw[l] = tiw; th[l] = tih;
      end
      if (comp) begin
        qw = shrink(pow2_ceil(wel), split);
        qh = shrink(pow2_ceil(hel), split);
      end else begin
        qw = pow2_ceil(shrink(wel, split));
        qh = pow2_ceil(shrink(hel, split));
      end
      for (int unsigned l = split; l < nlev; l++) begin
        off[l] = pos;
        pos = align_up(pos + bpb * qw * qh, CACHE_LINE_BYTES);
        if (comp) t = pow2_ceil((qw < qh) ? qw : qh);
        else t = pow2_ceil(shrink((wel < hel) ? wel : hel, l));
        tw[l] = t; th[l] = t;
        strd[l] = div_up(shrink(w, l), bw);
        qw = shrink(qw, 1); qh = shrink(qh, 1);
      end
      paged = (nlev != 1) && (pos > PAGE_BYTES);
      if (d == 1 && !fl[1]) paged = 0;
      if (fl[2]) paged = 1;
      if (fl[3] && d > 1) paged = 1;
      layer = paged ? align_up(pos, PAGE_BYTES) : pos;
      total = layer * d;
    end
    total = align_up(total, CACHE_LINE_BYTES);
    for (int unsigned l = 0; l < nlev; l++) begin
      e.level  = 4'(l);
      e.offset = 32'(clip(off[l], 64'hFFFF_FFFF));
      e.stride = 21'(clip(strd[l], 64'h1F_FFFF));
      e.tw     = 15'(clip(tw[l], 64'h7FFF));
      e.th     = 15'(clip(th[l], 64'h7FFF));
      e.last   = (l + 1 == nlev);
      e.layer  = e.last ? 32'(clip(layer, 64'hFFFF_FFFF)) : 32'd0;
      e.total  = e.last ? 44'(clip(total, 64'hFFF_FFFF_FFFF)) : 44'd0;
      e.paged  = paged;
      level_q.push_back(e);
    end
  endtask

  task automatic check_field(string name, u64 exp_v, u64 act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign levels_pending = level_q.size();

  always @(posedge clk) begin
    level_desc_t e;
    if (rst_n) begin
      if (start && !busy) predict_levels();
      if (out_valid) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected result, level %0d", $realtime, out_level_index);
          fail_count++;
        end else begin
          e = level_q.pop_front();
          check_field("level_index", e.level, out_level_index);
          check_field("level_offset", e.offset, out_level_offset);
          check_field("row_stride", e.stride, out_row_stride);
          check_field("tile_width", e.tw, out_tile_width);
          check_field("tile_height", e.th, out_tile_height);
          check_field("layer_stride", e.layer, out_layer_stride);
          check_field("total_size", e.total, out_total_size);
          check_field("page_aligned", e.paged, out_page_aligned);
          check_field("last_level", e.last, out_last_level);
        end
      end
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top for texture_miptree_layout: clock, reset, stimulus, verdict.
// Depends on tml_pkg, the block's RTL and tml_checker.
`timescale 1ns / 100ps
module tb_top;
  logic        clk = 0, rst_n = 0, start = 0, busy;
  logic        in_tiling_mode = 0;
  logic [14:0] in_width = 0, in_height = 0;
  logic [11:0] in_depth = 0;
  logic [6:0]  in_bytes_per_block = 0;
  logic [3:0]  in_block_width = 0, in_block_height = 0;
  logic [5:0]  in_usage_flags = 0;
  logic [20:0] in_forced_stride = 0;
  logic        out_valid, out_page_aligned, out_last_level;
  logic [3:0]  out_level_index;
  logic [31:0] out_level_offset, out_layer_stride;
  logic [20:0] out_row_stride;
  logic [14:0] out_tile_width, out_tile_height;
  logic [43:0] out_total_size;
  int          fail_count, levels_pending, cycles = 0;

  always #10 clk = ~clk;

  texture_miptree_layout dut (.*);
  tml_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send(bit tm, int w, int h, int d, int bpb, int bw, int bh,
                      int fl, int fs);
    repeat ($urandom_range(0, 19)) @(negedge clk);
    while (busy) @(negedge clk);
    in_tiling_mode = tm; in_width = 15'(w); in_height = 15'(h);
    in_depth = 12'(d); in_bytes_per_block = 7'(bpb);
    in_block_width = 4'(bw); in_block_height = 4'(bh);
    in_usage_flags = 6'(fl); in_forced_stride = 21'(fs);
    start = 1;
    @(negedge clk);
    start = 0;
  endtask

  function automatic int pick_size(int maxv);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 16);
      1: return $urandom_range(0, 512);
      2: return $urandom_range(0, maxv);
      default: return 1 << $urandom_range(0, 14);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // extremes, zero sizes, odd block sizes, forced stride, flag bits
    send(0, 1, 1, 1, 1, 1, 1, 0, 0);
    send(0, 32767, 32767, 4095, 127, 15, 15, 63, 0);
    send(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(0, 100, 50, 3, 4, 1, 1, 0, 2097151);
    send(0, 16384, 16384, 2048, 64, 1, 1, 0, 1);
    send(1, 1, 1, 1, 1, 1, 1, 0, 0);
    send(1, 16384, 16384, 1, 4, 1, 1, 16, 0);
    send(1, 32767, 32767, 4095, 127, 1, 1, 63, 2097151);
    send(1, 0, 0, 0, 0, 0, 0, 48, 0);
    send(1, 300, 200, 1, 3, 1, 1, 16, 0);
    send(1, 1000, 700, 1, 100, 1, 1, 17, 0);
    send(1, 4096, 4096, 1, 16, 4, 4, 17, 0);
    send(1, 4100, 3000, 1, 8, 12, 12, 17, 0);
    send(1, 8, 8, 4095, 2, 1, 1, 48, 0);
    send(1, 2048, 1024, 1, 32, 1, 1, 18, 0);
    send(1, 2048, 1024, 6, 32, 1, 1, 24, 0);
    send(1, 2048, 1024, 1, 32, 1, 1, 20, 0);
    send(1, 2000, 2000, 1, 64, 5, 7, 31, 0);
    send(1, 513, 257, 2, 2, 1, 1, 16, 0);
    send(1, 32767, 1, 1, 1, 1, 1, 16, 0);
    for (int i = 0; i < 250; i++) begin
      send($urandom_range(0, 4) != 0, pick_size(32767), pick_size(32767),
           ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 4),
           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                       : (1 << $urandom_range(0, 6)),
           $urandom_range(0, 15), $urandom_range(0, 15),
           $urandom_range(0, 63) | (($urandom_range(0, 3) != 0) ? 16 : 0),
           ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 2097151));
    end
    while (levels_pending != 0 || busy) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
